/* rtl/aip_pkg.sv */
// shared types, constants and helpers for the ascii integer parser
package aip_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int VALUE_W     = 64;
    localparam int END_W       = 16;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = 6;
    localparam int PROD_W      = VALUE_W + RADIX_W;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = Q_PTR_W + 1;
    localparam int DATA_OUT_W  = 80;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_AUTO  = RADIX_W'(0);
    localparam logic [RADIX_W-1:0] RADIX_ONE   = RADIX_W'(1);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] BASE_OCT    = RADIX_W'(8);
    localparam logic [RADIX_W-1:0] BASE_DEC    = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] BASE_HEX    = RADIX_W'(16);
    localparam logic [DIGIT_W-1:0] NO_DIGIT    = DIGIT_W'(36);

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [31:0]            END_CLAMP = 32'h0000_FFFF;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    typedef struct packed {
        logic               start;
        logic [RADIX_W-1:0] radix;
        logic               is_space;
        logic               is_minus;
        logic               is_plus;
        logic               is_zero;
        logic               is_x;
        logic [DIGIT_W-1:0] digit;
    } t_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [END_W-1:0]   end_offset;
        logic               digits_found;
        logic               overflowed;
    } t_result;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SPACE  = 6'b000010,
        PH_FIRST  = 6'b000100,
        PH_ZERO   = 6'b001000,
        PH_AFTERX = 6'b010000,
        PH_DIGITS = 6'b100000
    } t_phase;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
        logic [DIGIT_W-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_W'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = DIGIT_W'(c - CH_LO_A) + DIGIT_W'(10);
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = DIGIT_W'(c - CH_UP_A) + DIGIT_W'(10);
        end
        return d;
    endfunction

endpackage

/* rtl/aip_front.sv */
// front end: radix register, byte accept and character classification
module aip_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,
    input  logic [0:0]              s_axis_tuser,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [aip_pkg::RADIX_W-1:0] i_cfg_data,
    input  logic                    i_q_full,
    output logic                    o_q_wr,
    output aip_pkg::t_item          o_q_item
);
    import aip_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic [7:0]         c;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !i_q_full;
    assign o_q_wr        = s_axis_tvalid && !i_q_full;
    assign c             = s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_data;
        end
    end

    always_comb begin
        o_q_item.start    = s_axis_tuser[0];
        o_q_item.radix    = r_radix;
        o_q_item.is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                            (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
        o_q_item.is_minus = (c == CH_MINUS);
        o_q_item.is_plus  = (c == CH_PLUS);
        o_q_item.is_zero  = (c == CH_ZERO);
        o_q_item.is_x     = (c == CH_LO_X) || (c == CH_UP_X);
        o_q_item.digit    = digit_of(c);
    end

endmodule

/* rtl/aip_queue.sv */
// short queue of classified bytes between front and back
module aip_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  aip_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_valid,
    output aip_pkg::t_item o_item
);
    import aip_pkg::*;

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> r_count != '0)
        else $error("queue read while empty");

endmodule

/* rtl/aip_back.sv */
// back end: parse state machine, accumulator and result register
module aip_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  aip_pkg::t_item   i_q_item,
    output logic             o_q_rd,
    output logic             o_valid,
    input  logic             i_ready,
    output aip_pkg::t_result o_result
);
    import aip_pkg::*;

    t_phase                 r_phase;
    logic [VALUE_W-1:0]     r_acc;
    logic [RADIX_W-1:0]     r_base;
    logic                   r_minus;
    logic                   r_any;
    logic                   r_wrap;
    logic [OFFSET_BITS-1:0] r_cnt;
    logic                   r_out_valid;
    t_result                r_out;

    t_phase                 n_phase;
    logic [VALUE_W-1:0]     n_acc;
    logic [RADIX_W-1:0]     n_base;
    logic                   n_minus;
    logic                   n_any;
    logic                   n_wrap;
    logic [OFFSET_BITS-1:0] n_cnt;
    t_result                n_out;

    t_phase                 ph_in;
    logic                   emit;
    logic                   skip;
    logic                   first;
    logic                   take;
    logic [OFFSET_BITS-1:0] end_w;
    logic [31:0]            end_ext;
    logic [PROD_W-1:0]      prod;
    logic                   pop;

    assign pop      = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_rd   = pop;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_base  = r_base;
        n_minus = r_minus;
        n_any   = r_any;
        n_wrap  = r_wrap;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        skip    = 1'b0;
        first   = 1'b0;
        take    = 1'b0;
        end_w   = r_cnt;
        prod    = '0;

        if (i_q_item.start) begin
            n_acc   = '0;
            n_minus = 1'b0;
            n_any   = 1'b0;
            n_wrap  = 1'b0;
            n_cnt   = '0;
            n_base  = i_q_item.radix;
            if (i_q_item.radix == RADIX_ONE || i_q_item.radix > RADIX_MAX) begin
                emit    = 1'b1;
                skip    = 1'b1;
                end_w   = '0;
                n_phase = PH_IDLE;
            end else begin
                n_phase = PH_SPACE;
            end
        end
        ph_in = n_phase;

        if (!skip) begin
            unique case (ph_in)
                PH_IDLE: begin
                end
                PH_SPACE: begin
                    if (i_q_item.is_space) begin
                    end else if (i_q_item.is_minus) begin
                        n_minus = 1'b1;
                        n_phase = PH_FIRST;
                    end else if (i_q_item.is_plus) begin
                        n_phase = PH_FIRST;
                    end else begin
                        first = 1'b1;
                    end
                end
                PH_FIRST: begin
                    first = 1'b1;
                end
                PH_ZERO: begin
                    if (i_q_item.is_x && (n_base == RADIX_AUTO || n_base == BASE_HEX)) begin
                        n_base  = BASE_HEX;
                        n_phase = PH_AFTERX;
                    end else begin
                        if (n_base == RADIX_AUTO) begin
                            n_base = BASE_OCT;
                        end
                        take = 1'b1;
                    end
                end
                PH_AFTERX: begin
                    if (i_q_item.digit < DIGIT_W'(BASE_HEX)) begin
                        take = 1'b1;
                    end else begin
                        emit  = 1'b1;
                        end_w = (n_cnt == COUNT_MAX) ? COUNT_MAX
                                                     : n_cnt - OFFSET_BITS'(1);
                    end
                end
                PH_DIGITS: begin
                    take = 1'b1;
                end
                default: begin
                end
            endcase

            if (first) begin
                if (i_q_item.is_zero && (n_base == RADIX_AUTO || n_base == BASE_HEX)) begin
                    n_acc   = '0;
                    n_any   = 1'b1;
                    n_phase = PH_ZERO;
                end else begin
                    if (n_base == RADIX_AUTO) begin
                        n_base = BASE_DEC;
                    end
                    take = 1'b1;
                end
            end

            if (take) begin
                if (i_q_item.digit >= DIGIT_W'(n_base)) begin
                    emit  = 1'b1;
                    end_w = n_cnt;
                end else begin
                    prod    = PROD_W'(n_acc) * PROD_W'(n_base) + PROD_W'(i_q_item.digit);
                    n_wrap  = n_wrap | (|prod[PROD_W-1:VALUE_W]);
                    n_acc   = prod[VALUE_W-1:0];
                    n_any   = 1'b1;
                    n_phase = PH_DIGITS;
                end
            end

            if (emit) begin
                n_phase = PH_IDLE;
            end
            if (ph_in != PH_IDLE && n_cnt != COUNT_MAX) begin
                n_cnt = n_cnt + OFFSET_BITS'(1);
            end
        end

        end_ext            = 32'(end_w);
        n_out.value        = !n_any ? '0 : (n_minus ? (VALUE_W'(0) - n_acc) : n_acc);
        n_out.end_offset   = !n_any ? '0 :
                             ((end_ext > END_CLAMP) ? END_CLAMP[END_W-1:0] : end_ext[END_W-1:0]);
        n_out.digits_found = n_any;
        n_out.overflowed   = n_wrap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_base  <= '0;
            r_minus <= 1'b0;
            r_any   <= 1'b0;
            r_wrap  <= 1'b0;
            r_cnt   <= '0;
        end else if (pop) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_minus <= n_minus;
            r_any   <= n_any;
            r_wrap  <= n_wrap;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_out <= n_out;
        end
    end

    a_no_digit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.digits_found |-> r_out.value == '0 && r_out.end_offset == '0)
        else $error("result without digits carries a value");

    a_wrap_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrap && !(pop && i_q_item.start) |=> r_wrap)
        else $error("overflow flag dropped inside a string");

endmodule

/* rtl/ascii_integer_parser_core.sv */
// top level of the streaming ascii to integer parser
// the ending byte passes the queue; the back end then loads the result register on its pop
// throughput: one byte per cycle unless the queue is full; one base multiply-add per cycle
// a stalled result holds the back end, while the four-entry queue takes bytes until it is full
// reset: synchronous active-low i_rst_n clears the queue, the parse state and the result valid
// reset sets the radix register to 10
module ascii_integer_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ch
    input  logic [0:0]  s_axis_tuser,   // start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // value[63:0], end_offset[79:64]
    output logic [1:0]  m_axis_tuser,   // overflowed[1], digits_found[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data
);
    import aip_pkg::*;

    logic    q_wr;
    logic    q_full;
    logic    q_rd;
    logic    q_valid;
    t_item   wr_item;
    t_item   rd_item;
    t_result result;

    aip_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .o_q_item      (wr_item)
    );

    aip_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (wr_item),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_item  (rd_item)
    );

    aip_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (rd_item),
        .o_q_rd    (q_rd),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (result)
    );

    assign m_axis_tdata = {result.end_offset, result.value};
    assign m_axis_tuser = {result.overflowed, result.digits_found};

endmodule
